>>> rtl/mma_pkg.sv
// Shared constants and command/status types for the multichannel moving average.
// No dependencies; used by the top, controller and datapath through scoped names.
`default_nettype none

package mma_pkg;

    localparam int CHANNELS    = 4;
    localparam int WINDOW      = 8;
    localparam int WINDOW_LOG2 = 3;
    localparam int SAMPLE_BITS = 12;

    localparam int NUM_FIELDS   = 4;
    localparam int FIELD_BITS   = 12;
    localparam int TDATA_BITS   = ((NUM_FIELDS * FIELD_BITS + 7) / 8) * 8;
    localparam int SUM_BITS     = SAMPLE_BITS + WINDOW_LOG2 + 1;
    localparam int FILL_BITS    = $clog2(WINDOW + 1);
    localparam int PTR_BITS     = $clog2(WINDOW);
    localparam int ROW_BITS     = CHANNELS * SAMPLE_BITS;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS);

    typedef struct packed {
        logic load;
        logic upd;
        logic div_step;
        logic out_load;
    } mma_cmd_t;

    typedef struct packed {
        logic full;
        logic out_free;
    } mma_stat_t;

endpackage

`default_nettype wire

>>> rtl/multichannel_moving_average_top.sv
// Top level of the four-channel moving average filter.
// Depends on mma_pkg, mma_ctrl, mma_datapath (which holds mma_ram).
//
// channel | signals                    | content
// in      | s_tvalid s_tready s_tdata  | one ADC frame, sample_ch0..sample_ch3
// out     | m_tvalid m_tready m_tdata  | one averaged frame, avg_ch0..avg_ch3
//
// While the window fills, an item goes through accept, update,
// one restoring divide step per quotient bit in each channel lane, output load.
// Once the window is full, the divide is skipped: accept, update, output load.
// A result waits in the output register; the next item is accepted meanwhile, but not before the last is loaded there.
// rst_n clears sums, fill count, pointer and output valid; no clearing pass.
`default_nettype none

module multichannel_moving_average_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3
    input  wire logic [mma_pkg::TDATA_BITS-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // avg_ch0, avg_ch1, avg_ch2, avg_ch3
    output logic      [mma_pkg::TDATA_BITS-1:0] m_tdata
);

    mma_pkg::mma_cmd_t  cmd;
    mma_pkg::mma_stat_t stat;

    mma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mma_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mma_ctrl.sv
// Controller state machine: sequences accept, update, serial divide and output load.
// Depends on mma_pkg.
`default_nettype none

module mma_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire mma_pkg::mma_stat_t stat,
    output mma_pkg::mma_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                       state_reg, state_next;
    logic [mma_pkg::DIV_CNT_BITS-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.upd = 1'b1;
                if (stat.full)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next   = mma_pkg::DIV_CNT_BITS'(mma_pkg::SUM_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mma_datapath.sv
// Datapath: running sums, fill count, history RAM, per-channel serial dividers, output register.
// Depends on mma_pkg and mma_ram.
`default_nettype none

module mma_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mma_pkg::mma_cmd_t               cmd,
    output mma_pkg::mma_stat_t                   stat,
    input  wire logic [mma_pkg::TDATA_BITS-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [mma_pkg::TDATA_BITS-1:0]  m_tdata
);

    localparam int CH  = mma_pkg::CHANNELS;
    localparam int SB  = mma_pkg::SAMPLE_BITS;
    localparam int SUM = mma_pkg::SUM_BITS;
    localparam int FB  = mma_pkg::FILL_BITS;
    localparam int FLD = mma_pkg::FIELD_BITS;

    logic [SB-1:0]  samp_reg [CH];
    logic [SUM-1:0] sum_reg  [CH];
    logic [SUM-1:0] sum_next [CH];
    logic [SUM-1:0] quo_reg  [CH];
    logic [SUM-1:0] quo_next [CH];
    logic [FB-1:0]  rem_reg  [CH];
    logic [FB-1:0]  rem_next [CH];

    logic [FB-1:0]                   fill_reg, fill_next;
    logic [mma_pkg::PTR_BITS-1:0]    ptr_reg, ptr_next;
    logic [mma_pkg::ROW_BITS-1:0]    rd_row, wr_row;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [mma_pkg::TDATA_BITS-1:0]  m_tdata_reg, m_tdata_next;
    logic                            full;

    assign full          = (fill_reg == FB'(mma_pkg::WINDOW));
    assign stat.full     = full;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            wr_row[c*SB +: SB] = samp_reg[c];
        end
    end

    mma_ram #(
        .WIDTH (mma_pkg::ROW_BITS),
        .DEPTH (mma_pkg::WINDOW)
    ) u_hist (
        .clk     (clk),
        .wr_en   (cmd.upd),
        .wr_addr (ptr_reg),
        .wr_data (wr_row),
        .rd_en   (cmd.load),
        .rd_addr (ptr_reg),
        .rd_data (rd_row)
    );

    always_comb
    begin
        logic [SUM-1:0] old_v;
        logic [SUM-1:0] base;
        logic [FB:0]    trial;
        old_v     = '0;
        base      = '0;
        trial     = '0;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        for (int c = 0; c < CH; c++)
        begin
            sum_next[c] = sum_reg[c];
            quo_next[c] = quo_reg[c];
            rem_next[c] = rem_reg[c];
        end
        if (cmd.upd)
        begin
            fill_next = full ? fill_reg : fill_reg + 1'b1;
            ptr_next  = (ptr_reg == mma_pkg::PTR_BITS'(mma_pkg::WINDOW - 1))
                        ? '0 : ptr_reg + 1'b1;
            for (int c = 0; c < CH; c++)
            begin
                old_v = SUM'(rd_row[c*SB +: SB]);
                if (!full)
                begin
                    base = sum_reg[c];
                end
                else if (old_v > sum_reg[c])
                begin
                    base = '0;
                end
                else
                begin
                    base = sum_reg[c] - old_v;
                end
                sum_next[c] = base + SUM'(samp_reg[c]);
                quo_next[c] = full ? (sum_next[c] >> mma_pkg::WINDOW_LOG2) : sum_next[c];
                rem_next[c] = '0;
            end
        end
        else if (cmd.div_step)
        begin
            // restoring divide by the fill count, one quotient bit per cycle
            for (int c = 0; c < CH; c++)
            begin
                trial = {rem_reg[c], quo_reg[c][SUM-1]};
                if (trial >= {1'b0, fill_reg})
                begin
                    rem_next[c] = FB'(trial - {1'b0, fill_reg});
                    quo_next[c] = {quo_reg[c][SUM-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = trial[FB-1:0];
                    quo_next[c] = {quo_reg[c][SUM-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            for (int f = 0; f < mma_pkg::NUM_FIELDS; f++)
            begin
                if (f < CH)
                begin
                    m_tdata_next[f*FLD +: FLD] = FLD'(quo_reg[f]);
                end
            end
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < CH; c++)
        begin
            if (cmd.load)
            begin
                samp_reg[c] <= SB'(s_tdata[c*FLD +: FLD]);
            end
            quo_reg[c] <= quo_next[c];
            rem_reg[c] <= rem_next[c];
        end
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH; c++)
            begin
                sum_reg[c] <= '0;
            end
            fill_reg     <= '0;
            ptr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            for (int c = 0; c < CH; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FB'(mma_pkg::WINDOW))
        else $error("fill count beyond window");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= mma_pkg::PTR_BITS'(mma_pkg::WINDOW - 1))
        else $error("history pointer out of range");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> full)
        else $error("window left full state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten before taken");

    a_fill_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (!full && fill_reg != FB'(0)) |-> (FB'(ptr_reg) == fill_reg))
        else $error("pointer and fill count disagree while filling");

endmodule

`default_nettype wire

>>> tb/multichannel_moving_average_top_test.sv
// Testbench for the four-channel moving average filter: fill phase, steady state,
// extreme and random samples, with bursty input and a stalling output side.
// Depends on mma_pkg and multichannel_moving_average_top.
`timescale 1ns / 100ps

module multichannel_moving_average_top_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_FRAMES = 1425;

    typedef logic [mma_pkg::NUM_FIELDS-1:0][mma_pkg::FIELD_BITS-1:0] frame_t;

    class frame_average_scoreboard;
        logic [mma_pkg::SAMPLE_BITS-1:0] history[mma_pkg::WINDOW][mma_pkg::CHANNELS];
        logic [mma_pkg::SUM_BITS-1:0]    sums[mma_pkg::CHANNELS];
        logic [mma_pkg::FILL_BITS-1:0]   fill;
        logic [mma_pkg::PTR_BITS-1:0]    slot;
        frame_t                          expected_avgs[$];
        int                              mismatches;
        int                              frames_in;
        int                              frames_checked;

        function new();
            foreach (sums[ch])
                sums[ch] = '0;
            fill = '0;
            slot = '0;
            mismatches = 0;
            frames_in = 0;
            frames_checked = 0;
        endfunction

        function int pending();
            return expected_avgs.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void note_frame(frame_t samples);
            frame_t                          avgs;
            bit                              full;
            logic [mma_pkg::SAMPLE_BITS-1:0] s;
            logic [mma_pkg::SUM_BITS-1:0]    q;
            full = (fill >= mma_pkg::WINDOW);
            if (!full)
                fill++;
            avgs = '0;
            for (int ch = 0; ch < mma_pkg::CHANNELS; ch++)
            begin
                s = samples[ch][mma_pkg::SAMPLE_BITS-1:0];
                if (!full)
                begin
                    sums[ch] = sums[ch] + s;
                    q = sums[ch] / fill;
                end
                else
                begin
                    // running sum saturates at zero before the new sample goes in
                    if (history[slot][ch] > sums[ch])
                        sums[ch] = '0;
                    else
                        sums[ch] = sums[ch] - history[slot][ch];
                    sums[ch] = sums[ch] + s;
                    q = sums[ch] >> mma_pkg::WINDOW_LOG2;
                end
                history[slot][ch] = s;
                avgs[ch] = q[mma_pkg::FIELD_BITS-1:0];
            end
            slot = (slot == mma_pkg::WINDOW - 1) ? '0 : slot + 1'b1;
            expected_avgs.push_back(avgs);
            frames_in++;
        endfunction

        function void check_result(frame_t got);
            frame_t want;
            if (expected_avgs.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_avgs.pop_front();
            frames_checked++;
            for (int ch = 0; ch < mma_pkg::NUM_FIELDS; ch++)
                if (got[ch] !== want[ch])
                    report($sformatf("result %0d avg_ch%0d expected %0d got %0d",
                                     frames_checked, ch, want[ch], got[ch]));
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [mma_pkg::TDATA_BITS-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [mma_pkg::TDATA_BITS-1:0] m_tdata;

    frame_average_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    int ready_pct = 100;

    multichannel_moving_average_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: stall density is redrawn at random from a set of ready percentages
    initial
    begin
        int pcts[4];
        pcts = '{100, 80, 45, 12};
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata[mma_pkg::NUM_FIELDS*mma_pkg::FIELD_BITS-1:0]);
            if (cycles % 96 == 0)
                ready_pct = pcts[$urandom_range(0, 3)];
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    function automatic logic [mma_pkg::FIELD_BITS-1:0] pick_sample();
        logic [mma_pkg::FIELD_BITS-1:0] one_hot;
        one_hot = '0;
        one_hot[$urandom_range(0, mma_pkg::FIELD_BITS - 1)] = 1'b1;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 15);
            3: return one_hot;
            4: return ~one_hot;
            default: return $urandom_range(0, (1 << mma_pkg::FIELD_BITS) - 1);
        endcase
    endfunction

    task automatic send_frame(frame_t f);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_frame(f);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        frame_t f;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window fill: mixed extremes per channel
        for (int i = 0; i < mma_pkg::WINDOW; i++)
        begin
            f[0] = '1;
            f[1] = '0;
            f[2] = i * 511;
            f[3] = (i % 2) ? 12'hAAA : 12'h555;
            send_frame(f);
        end
        for (int i = 0; i < mma_pkg::WINDOW; i++)
            send_frame('1);
        for (int i = 0; i < mma_pkg::WINDOW; i++)
            send_frame('0);
        drain();

        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n % 300 == 299)
                drain();
            // sometimes hold a channel steady so its average settles
            for (int ch = 0; ch < mma_pkg::NUM_FIELDS; ch++)
                if (n == 0 || $urandom_range(0, 3) != 0)
                    f[ch] = pick_sample();
            send_frame(f);
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Sent %0d frames: window fill, full-scale and zero runs, then random",
                 sb.frames_in);
        $display("samples under bursty input and output stalls; %0d results checked.",
                 sb.frames_checked);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
